>>> sv/dfd_pkg.sv
// Shared types and constants for the delimited frame deframer.
// No dependencies; imported by every dfd module.
package dfd_pkg;

    localparam int unsigned CFG_INDEX_W = 3;
    localparam int unsigned CFG_DATA_W  = 16;
    localparam int unsigned POS_W       = 17;
    localparam int unsigned ERR_W       = 32;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_START_DELIM  = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_END_DELIM    = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_MAX_LEN      = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_CODE_DISC    = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_CODE_HBEAT   = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_CODE_DATARSP = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] CFG_CODE_STREAM  = 3'd6;

    // Header layout
    localparam logic [POS_W-1:0] POS_SOURCE   = 17'd2;
    localparam logic [POS_W-1:0] POS_TYPE     = 17'd4;
    localparam logic [POS_W-1:0] POS_LEN_LO   = 17'd5;
    localparam logic [POS_W-1:0] POS_LEN_HI   = 17'd6;
    localparam logic [POS_W-1:0] POS_HDR_LAST = 17'd8;
    localparam logic [POS_W-1:0] HDR_BYTES    = 17'd9;
    // header plus two CRC bytes: position of the end delimiter, before the payload length is added
    localparam logic [POS_W-1:0] END_OFFSET   = 17'd11;

    // Result item kinds
    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_STATUS  = 1'b1;

    // Frame status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_BAD_END = 2'd1;
    localparam logic [1:0] ST_TOO_LONG = 2'd2;

    // Message classes
    localparam logic [1:0] MC_DISCOVERY = 2'd0;
    localparam logic [1:0] MC_HEARTBEAT = 2'd1;
    localparam logic [1:0] MC_DATA      = 2'd2;
    localparam logic [1:0] MC_OTHER     = 2'd3;

    typedef struct packed {
        logic [7:0]  start_delim;
        logic [7:0]  end_delim;
        logic [15:0] max_len;
        logic [7:0]  code_disc;
        logic [7:0]  code_hbeat;
        logic [7:0]  code_datarsp;
        logic [7:0]  code_stream;
    } t_cfg;

    typedef struct packed {
        logic             kind;
        logic [7:0]       data;
        logic [7:0]       source;
        logic [1:0]       mclass;
        logic [1:0]       status;
        logic [15:0]      length;
        logic [ERR_W-1:0] err_count;
    } t_result;

endpackage

>>> sv/dfd_cfg_regs.sv
// Configuration register file of the deframer.
// Depends on dfd_pkg (t_cfg, register indexes).
module dfd_cfg_regs
    import dfd_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_wr_en,
    input  logic [CFG_INDEX_W-1:0] i_wr_index,
    input  logic [CFG_DATA_W-1:0]  i_wr_data,
    output t_cfg                   o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_wr_en) begin
            unique case (i_wr_index)
                CFG_START_DELIM:  n_cfg.start_delim  = i_wr_data[7:0];
                CFG_END_DELIM:    n_cfg.end_delim    = i_wr_data[7:0];
                CFG_MAX_LEN:      n_cfg.max_len      = i_wr_data;
                CFG_CODE_DISC:    n_cfg.code_disc    = i_wr_data[7:0];
                CFG_CODE_HBEAT:   n_cfg.code_hbeat   = i_wr_data[7:0];
                CFG_CODE_DATARSP: n_cfg.code_datarsp = i_wr_data[7:0];
                CFG_CODE_STREAM:  n_cfg.code_stream  = i_wr_data[7:0];
                default:          n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.start_delim  <= 8'd170;
            r_cfg.end_delim    <= 8'd85;
            r_cfg.max_len      <= 16'd256;
            r_cfg.code_disc    <= 8'd2;
            r_cfg.code_hbeat   <= 8'd3;
            r_cfg.code_datarsp <= 8'd4;
            r_cfg.code_stream  <= 8'd5;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

>>> sv/dfd_parser.sv
// Frame parser: hunt, header capture, payload pass-through, trailer check.
// Depends on dfd_pkg (t_cfg, t_result, layout and status constants).
module dfd_parser
    import dfd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cfg       i_cfg,
    input  logic       i_advance,
    input  logic [7:0] i_byte,
    output logic       o_emit,
    output t_result    o_result
);

    logic             r_in_frame, n_in_frame;
    logic             r_hdr_done, n_hdr_done;
    logic [POS_W-1:0] r_pos,      n_pos;
    logic [POS_W-1:0] r_pay_end,  n_pay_end;
    logic [POS_W-1:0] r_last_pos, n_last_pos;
    logic [7:0]       r_source,   n_source;
    logic [7:0]       r_type,     n_type;
    logic [15:0]      r_length,   n_length;
    logic [ERR_W-1:0] r_err,      n_err;
    logic [ERR_W-1:0] err_inc;
    logic [POS_W-1:0] len_ext;
    logic [1:0]       mclass;

    assign len_ext = {{(POS_W-16){1'b0}}, r_length};
    assign err_inc = (r_err != {ERR_W{1'b1}}) ? r_err + 1'b1 : r_err;

    // Earlier code matches win
    always_comb begin
        priority if (r_type == i_cfg.code_disc) begin
            mclass = MC_DISCOVERY;
        end else if (r_type == i_cfg.code_hbeat) begin
            mclass = MC_HEARTBEAT;
        end else if (r_type == i_cfg.code_datarsp || r_type == i_cfg.code_stream) begin
            mclass = MC_DATA;
        end else begin
            mclass = MC_OTHER;
        end
    end

    always_comb begin
        n_in_frame = r_in_frame;
        n_hdr_done = r_hdr_done;
        n_pos      = r_pos;
        n_pay_end  = r_pay_end;
        n_last_pos = r_last_pos;
        n_source   = r_source;
        n_type     = r_type;
        n_length   = r_length;
        n_err      = r_err;
        o_emit     = 1'b0;
        o_result.kind   = KIND_PAYLOAD;
        o_result.data   = 8'd0;
        o_result.status = ST_OK;
        o_result.source = r_source;
        o_result.mclass = mclass;
        o_result.length = r_length;

        if (i_advance) begin
            if (!r_in_frame) begin
                if (i_byte == i_cfg.start_delim) begin
                    n_in_frame = 1'b1;
                    n_hdr_done = 1'b0;
                    n_pos      = POS_W'(1);
                end
            end else begin
                n_pos = r_pos + 1'b1;
                if (!r_hdr_done) begin
                    if (r_pos == POS_SOURCE) begin
                        n_source = i_byte;
                    end else if (r_pos == POS_TYPE) begin
                        n_type = i_byte;
                    end else if (r_pos == POS_LEN_LO) begin
                        n_length = {r_length[15:8], i_byte};
                    end else if (r_pos == POS_LEN_HI) begin
                        n_length = {i_byte, r_length[7:0]};
                    end else if (r_pos == POS_HDR_LAST) begin
                        if (r_length > i_cfg.max_len) begin
                            // abort: report and drop back to hunting
                            n_err           = err_inc;
                            o_emit          = 1'b1;
                            o_result.kind   = KIND_STATUS;
                            o_result.status = ST_TOO_LONG;
                            n_in_frame      = 1'b0;
                            n_pos           = '0;
                        end else begin
                            n_hdr_done = 1'b1;
                            n_pay_end  = HDR_BYTES + len_ext;
                            n_last_pos = END_OFFSET + len_ext;
                        end
                    end
                end else if (r_pos < r_pay_end) begin
                    o_emit        = 1'b1;
                    o_result.data = i_byte;
                end else if (r_pos >= r_last_pos) begin
                    o_emit        = 1'b1;
                    o_result.kind = KIND_STATUS;
                    if (i_byte != i_cfg.end_delim) begin
                        n_err           = err_inc;
                        o_result.status = ST_BAD_END;
                    end
                    n_in_frame = 1'b0;
                    n_hdr_done = 1'b0;
                    n_pos      = '0;
                end
            end
        end

        o_result.err_count = n_err;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_frame <= 1'b0;
            r_hdr_done <= 1'b0;
            r_pos      <= '0;
            r_source   <= '0;
            r_type     <= '0;
            r_length   <= '0;
            r_err      <= '0;
        end else begin
            r_in_frame <= n_in_frame;
            r_hdr_done <= n_hdr_done;
            r_pos      <= n_pos;
            r_source   <= n_source;
            r_type     <= n_type;
            r_length   <= n_length;
            r_err      <= n_err;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pay_end  <= n_pay_end;
        r_last_pos <= n_last_pos;
    end

endmodule

>>> sv/dfd_out_stage.sv
// Result register of the deframer, holds a beat until the consumer takes it.
// Depends on dfd_pkg (t_result).
module dfd_out_stage
    import dfd_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_load,
    input  t_result i_result,
    input  logic    i_stall,
    output logic    o_free,
    output logic    o_valid,
    output t_result o_result
);

    logic    r_valid, n_valid;
    t_result r_result;

    assign o_free = !r_valid || !i_stall;

    always_comb begin
        n_valid = r_valid;
        if (o_free) begin
            n_valid = i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_free && i_load) begin
            r_result <= i_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

>>> sv/delimited_frame_deframer_top.sv
// Top level of the delimited, length-prefixed frame deframer.
// Depends on dfd_pkg, dfd_cfg_regs, dfd_parser and dfd_out_stage.
//
//  channel  | handshake                  | payload
//  ---------+----------------------------+-----------------------------------------
//  rx in    | i_in_valid / o_in_stall    | i_rx_byte
//  result   | o_out_valid / i_out_stall  | o_item_kind .. o_error_count (7 fields)
//  config   | i_cfg_valid / o_cfg_ready  | i_cfg_index, i_cfg_data
//
// One byte per cycle, sustained while the consumer does not stall. A byte is held
// in the input register and is parsed on its way into the result register.
// The input side stalls only while the input register is full and the result
// register holds a beat the consumer stalls.
// Synchronous active-low reset: hunting for a start delimiter, counter at zero,
// registers at their defaults. The config port is always ready.
module delimited_frame_deframer_top
    import dfd_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // received byte channel
    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    input  logic [7:0]             i_rx_byte,
    // result channel
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output logic                   o_item_kind,
    output logic [7:0]             o_data_byte,
    output logic [7:0]             o_source_address,
    output logic [1:0]             o_message_class,
    output logic [1:0]             o_frame_status,
    output logic [15:0]            o_payload_length,
    output logic [ERR_W-1:0]       o_error_count,
    // configuration write channel
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data
);

    t_cfg    cfg;
    t_result parse_result;
    t_result out_result;
    logic    parse_emit;
    logic    out_free;
    logic    advance;
    logic    in_accept;

    logic       r_in_valid, n_in_valid;
    logic [7:0] r_in_byte;

    assign o_cfg_ready = 1'b1;

    dfd_cfg_regs u_cfg_regs (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_en    (i_cfg_valid && o_cfg_ready),
        .i_wr_index (i_cfg_index),
        .i_wr_data  (i_cfg_data),
        .o_cfg      (cfg)
    );

    // Parse the held byte whenever the result register can take a beat.
    assign advance    = r_in_valid && out_free;
    assign o_in_stall = r_in_valid && !out_free;
    assign in_accept  = i_in_valid && !o_in_stall;

    always_comb begin
        n_in_valid = r_in_valid;
        if (in_accept) begin
            n_in_valid = 1'b1;
        end else if (advance) begin
            n_in_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= n_in_valid;
        end
    end

    // Capture the byte on accept; hold it while stalled.
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in_byte <= i_rx_byte;
        end
    end

    dfd_parser u_parser (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (cfg),
        .i_advance(advance),
        .i_byte   (r_in_byte),
        .o_emit   (parse_emit),
        .o_result (parse_result)
    );

    dfd_out_stage u_out_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (parse_emit),
        .i_result(parse_result),
        .i_stall (i_out_stall),
        .o_free  (out_free),
        .o_valid (o_out_valid),
        .o_result(out_result)
    );

    assign o_item_kind      = out_result.kind;
    assign o_data_byte      = out_result.data;
    assign o_source_address = out_result.source;
    assign o_message_class  = out_result.mclass;
    assign o_frame_status   = out_result.status;
    assign o_payload_length = out_result.length;
    assign o_error_count    = out_result.err_count;

endmodule
